[rtl/core/mjs_pkg.sv]
// ----------------------------------------------------------------------------
// mjs_pkg
// Shared types, codes and helper functions of the multi-core job scheduler.
// ----------------------------------------------------------------------------
package mjs_pkg;

	localparam int MAX_CORES_DEF = 8;
	localparam int MAX_JOBS_DEF  = 64;

	localparam logic [1:0] OP_NEW     = 2'd0;
	localparam logic [1:0] OP_FINISH  = 2'd1;
	localparam logic [1:0] OP_QUANTUM = 2'd2;

	localparam logic [1:0] STAT_PLACED = 2'd0;
	localparam logic [1:0] STAT_NONE   = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	localparam logic [2:0] SCH_FCFS = 3'd0;
	localparam logic [2:0] SCH_SJF  = 3'd1;
	localparam logic [2:0] SCH_PSJF = 3'd2;
	localparam logic [2:0] SCH_PRI  = 3'd3;
	localparam logic [2:0] SCH_PPRI = 3'd4;
	localparam logic [2:0] SCH_RR   = 3'd5;

	localparam logic CFG_SCHEME = 1'b0;
	localparam logic CFG_CORES  = 1'b1;

	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NEW,
		S_SCAN,
		S_PLACE,
		S_VIC,
		S_EV,
		S_EV_HELD,
		S_EV_POP,
		S_EV_HEAD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] left;
		logic [7:0]  urg;
		logic [31:0] arr;
	} qkey_t;

	typedef struct packed {
		logic [15:0] job;
		logic [31:0] arr;
		logic [7:0]  urg;
		logic [15:0] left;
		logic [15:0] len;
		logic [32:0] first;
		logic [31:0] last;
		logic [32:0] prev;
	} rec_t;

	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

	function automatic logic goes_before(input logic [2:0] scheme, input qkey_t a,
		input qkey_t b);
		logic r;
		unique case (scheme)
			SCH_SJF, SCH_PSJF: r = (a.left != b.left) ? (a.left < b.left) : (a.arr < b.arr);
			SCH_PRI, SCH_PPRI: r = (a.urg != b.urg) ? (a.urg < b.urg) : (a.arr < b.arr);
			default:           r = 1'b0;
		endcase
		return r;
	endfunction

	// saturating add of a term that may be negative
	function automatic logic [47:0] add48(input logic [47:0] sum,
		input logic signed [33:0] term);
		logic [47:0] t;
		t = {14'd0, term[33:0]};
		if (term <= 34'sd0) return sum;
		if (t >= MAX48 - sum) return MAX48;
		return sum + t;
	endfunction

endpackage

[rtl/core/multicore_job_scheduler_top.sv]
// ----------------------------------------------------------------------------
// multicore_job_scheduler_top
// Event-driven job scheduler over several cores with a sorted wait queue.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  in      | in_valid / in_stall      | opcode job_id now run_length prio_level core_id
//  out     | out_valid / out_stall    | status core_index run_job_id done_count
//          |                          | wait_total turnaround_total response_total
//  cfg     | cfg_we                   | cfg_index cfg_data
//
// One event at a time; no clearing pass after reset. New job on an idle core: S_NEW.
// Preemptive new job with all cores busy: S_SCAN over the n usable cores, S_PLACE,
// S_VIC if a job is displaced; the scan reads one running job record per cycle
// from the record memory. Finish or quantum: S_EV, S_EV_HELD, S_EV_POP, S_EV_HEAD.
// in_stall stays high from an accepted beat until its result is registered;
// a stalled result beat holds while the next event is accepted.
module multicore_job_scheduler_top import mjs_pkg::*; #(
	parameter int MAX_CORES = MAX_CORES_DEF,
	parameter int MAX_JOBS  = MAX_JOBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] job_id,
	input  logic [31:0] now,
	input  logic [15:0] run_length,
	input  logic [7:0]  prio_level,
	input  logic [2:0]  core_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [2:0]  core_index,
	output logic [15:0] run_job_id,
	output logic [31:0] done_count,
	output logic [47:0] wait_total,
	output logic [47:0] turnaround_total,
	output logic [47:0] response_total,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int JW = $clog2(MAX_JOBS);
	localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int NW = $clog2(MAX_CORES + 1);

	state_t state_q, state_d;

	logic [2:0]  scheme_q;
	logic [3:0]  cores_q;
	logic [1:0]  op_q;
	logic [15:0] id_q;
	logic [31:0] now_q;
	logic [15:0] len_q;
	logic [7:0]  pr_q;
	logic [2:0]  core_q;
	logic [JW-1:0] slot_q;
	logic          in_use_q [MAX_JOBS];
	logic          hold_v_q [MAX_CORES];
	logic [JW-1:0] hold_idx_q [MAX_CORES];
	logic [NW-1:0] scan_q;
	logic          best_v_q;
	logic [CW-1:0] best_core_q;
	rec_t          best_rec_q;
	logic signed [33:0] best_eff_q;
	logic          held_v_q;
	rec_t          held_rec_q;
	logic [JW-1:0] head_q;
	logic signed [33:0] t_turn_q, t_wait_q, t_resp_q;
	logic [31:0] sum_done_q;
	logic [47:0] sum_wait_q, sum_turn_q, sum_resp_q;
	logic [1:0]  res_status_q;
	logic [2:0]  res_core_q;
	logic [15:0] res_jid_q;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [2:0]  core_index_q;
	logic [15:0] run_job_id_q;
	logic [31:0] done_count_q;
	logic [47:0] wait_total_q, turnaround_total_q, response_total_q;

	// record memory
	rec_t          mem [MAX_JOBS];
	rec_t          rd_q;
	logic          mem_we;
	logic [JW-1:0] mem_waddr, mem_raddr;
	rec_t          mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	// wait queue
	qctl_t         q_ctl;
	logic [JW-1:0] push_idx, q_head;
	qkey_t         push_key;
	logic          q_empty, q_full;

	mjs_queue #(.DEPTH(MAX_JOBS), .IW(JW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.scheme   (scheme_q),
		.ctl      (q_ctl),
		.push_idx (push_idx),
		.push_key (push_key),
		.head_idx (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	logic          accept, out_free, preempt_mode;
	logic [NW-1:0] n_use;
	logic          free_v, idle_v, core_ok;
	logic [JW-1:0] free_idx;
	logic [CW-1:0] idle_core, cidx;
	logic [31:0]   dlt;
	logic signed [33:0] eff, turn, wt, rsp;
	logic          cand;
	rec_t          vic_rec, hd_rec, new_rec;
	logic [31:0]   prev32;

	assign accept       = in_valid && !in_stall;
	assign out_free     = !out_valid_q || !out_stall;
	assign preempt_mode = (scheme_q == SCH_PSJF) || (scheme_q == SCH_PPRI);
	assign n_use        = (32'(cores_q) > MAX_CORES) ? NW'(MAX_CORES) : NW'(cores_q);
	assign core_ok      = 32'(core_q) < MAX_CORES;
	assign cidx         = CW'(core_q);

	always_comb begin
		free_v   = 1'b0;
		free_idx = '0;
		for (int r = MAX_JOBS - 1; r >= 0; r--) begin
			if (!in_use_q[r]) begin
				free_v   = 1'b1;
				free_idx = JW'(r);
			end
		end
		idle_v    = 1'b0;
		idle_core = '0;
		for (int c = MAX_CORES - 1; c >= 0; c--) begin
			if (c < 32'(n_use) && !hold_v_q[c]) begin
				idle_v    = 1'b1;
				idle_core = CW'(c);
			end
		end
	end

	// candidate test on the record read for the previous scan step
	always_comb begin
		dlt = now_q - rd_q.last;
		eff = $signed({18'd0, rd_q.left}) - $signed({{2{dlt[31]}}, dlt});
		if (scheme_q == SCH_PPRI) begin
			cand = (rd_q.urg > pr_q) && (!best_v_q || rd_q.urg > best_rec_q.urg ||
				(rd_q.urg == best_rec_q.urg && best_rec_q.arr < rd_q.arr));
		end else if (scheme_q == SCH_PSJF) begin
			cand = (eff > $signed({18'd0, len_q})) && (!best_v_q || eff > best_eff_q);
		end else begin
			cand = 1'b0;
		end
	end

	always_comb begin
		turn = $signed({2'b0, now_q}) - $signed({2'b0, rd_q.arr});
		wt   = turn - $signed({18'd0, rd_q.len});
		rsp  = rd_q.first[32] ? $signed({2'b0, rd_q.first[31:0]}) - $signed({2'b0, rd_q.arr})
			: 34'sd0;
	end

	// displaced job: new time left under PSJF, then undo a start that happened this tick
	always_comb begin
		vic_rec = best_rec_q;
		if (scheme_q == SCH_PSJF) begin
			vic_rec.left = (best_eff_q > 34'sd65535) ? 16'hFFFF : best_eff_q[15:0];
		end
		prev32 = vic_rec.prev[32] ? vic_rec.prev[31:0] : 32'hFFFF_FFFF;
		if (vic_rec.first[32] && vic_rec.first[31:0] == now_q) begin
			vic_rec.first = '0;
			vic_rec.last  = prev32;
		end else if (vic_rec.last == now_q) begin
			vic_rec.last = prev32;
		end
	end

	always_comb begin
		hd_rec = rd_q;
		if (!rd_q.first[32]) begin
			if (op_q == OP_FINISH) hd_rec.prev = '0;
			hd_rec.first = {1'b1, now_q};
		end else if (op_q == OP_FINISH) begin
			hd_rec.prev = {1'b1, rd_q.last};
		end
		hd_rec.last = now_q;
	end

	always_comb begin
		new_rec       = '0;
		new_rec.job   = id_q;
		new_rec.arr   = now_q;
		new_rec.urg   = pr_q;
		new_rec.left  = len_q;
		new_rec.len   = len_q;
		if (state_q == S_NEW) begin
			if (idle_v) new_rec.first = {1'b1, now_q};
			if (idle_v && preempt_mode) new_rec.last = now_q;
		end else if (best_v_q) begin
			new_rec.first = {1'b1, now_q};
			new_rec.last  = now_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_NEW) state_d = S_NEW;
					else if (opcode == OP_FINISH || opcode == OP_QUANTUM) state_d = S_EV;
					else state_d = S_DONE;
				end
			end
			S_NEW: begin
				if (free_v && !idle_v && preempt_mode) state_d = S_SCAN;
				else state_d = S_DONE;
			end
			S_SCAN:    if (scan_q == n_use) state_d = S_PLACE;
			S_PLACE:   state_d = best_v_q ? S_VIC : S_DONE;
			S_VIC:     state_d = S_DONE;
			S_EV: begin
				if (!core_ok) state_d = S_DONE;
				else if (hold_v_q[cidx]) state_d = S_EV_HELD;
				else state_d = S_EV_POP;
			end
			S_EV_HELD: state_d = S_EV_POP;
			S_EV_POP:  state_d = q_empty ? S_DONE : S_EV_HEAD;
			S_EV_HEAD: state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory and queue controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_rec;
		mem_raddr = '0;
		q_ctl     = '0;
		push_idx  = '0;
		push_key  = '{left: len_q, urg: pr_q, arr: now_q};
		unique case (state_q)
			S_NEW: begin
				mem_waddr = free_idx;
				mem_we    = free_v && (idle_v || !preempt_mode);
				push_idx  = free_idx;
				q_ctl.push = free_v && !idle_v && !preempt_mode && !q_full;
			end
			S_SCAN: begin
				if (scan_q < n_use) mem_raddr = hold_idx_q[scan_q[CW-1:0]];
			end
			S_PLACE: begin
				mem_we     = 1'b1;
				mem_waddr  = slot_q;
				push_idx   = slot_q;
				q_ctl.push = !best_v_q && !q_full;
			end
			S_VIC: begin
				mem_we     = 1'b1;
				mem_waddr  = hold_idx_q[best_core_q];
				mem_wdata  = vic_rec;
				push_idx   = hold_idx_q[best_core_q];
				push_key   = '{left: vic_rec.left, urg: vic_rec.urg, arr: vic_rec.arr};
				q_ctl.push = !q_full;
			end
			S_EV: begin
				if (core_ok) mem_raddr = hold_idx_q[cidx];
			end
			S_EV_POP: begin
				mem_raddr = q_head;
				q_ctl.pop = !q_empty;
			end
			S_EV_HEAD: begin
				mem_we     = 1'b1;
				mem_waddr  = head_q;
				mem_wdata  = hd_rec;
				push_idx   = hold_idx_q[cidx];
				push_key   = '{left: held_rec_q.left, urg: held_rec_q.urg,
					arr: held_rec_q.arr};
				q_ctl.push = (op_q == OP_QUANTUM) && held_v_q && !q_full;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scheme_q    <= SCH_FCFS;
			cores_q     <= 4'd1;
			scan_q      <= '0;
			best_v_q    <= 1'b0;
			held_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			sum_done_q  <= '0;
			sum_wait_q  <= '0;
			sum_turn_q  <= '0;
			sum_resp_q  <= '0;
			for (int r = 0; r < MAX_JOBS; r++) in_use_q[r] <= 1'b0;
			for (int c = 0; c < MAX_CORES; c++) hold_v_q[c] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_SCHEME) scheme_q <= cfg_data[2:0];
				else cores_q <= cfg_data;
			end
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					scan_q   <= '0;
					best_v_q <= 1'b0;
					held_v_q <= 1'b0;
				end
				S_NEW: begin
					if (free_v) begin
						in_use_q[free_idx] <= 1'b1;
						if (idle_v) hold_v_q[idle_core] <= 1'b1;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q != '0 && cand) best_v_q <= 1'b1;
				end
				S_EV: held_v_q <= core_ok && hold_v_q[cidx];
				S_EV_HELD: begin
					if (op_q == OP_FINISH) begin
						in_use_q[hold_idx_q[cidx]] <= 1'b0;
						hold_v_q[cidx]             <= 1'b0;
					end
				end
				S_EV_POP: begin
					if (op_q == OP_FINISH && held_v_q) begin
						if (sum_done_q != 32'hFFFF_FFFF) sum_done_q <= sum_done_q + 1'b1;
						sum_wait_q <= add48(sum_wait_q, t_wait_q);
						sum_turn_q <= add48(sum_turn_q, t_turn_q);
						sum_resp_q <= add48(sum_resp_q, t_resp_q);
					end
				end
				S_EV_HEAD: hold_v_q[cidx] <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= opcode;
					id_q         <= job_id;
					now_q        <= now;
					len_q        <= run_length;
					pr_q         <= prio_level;
					core_q       <= core_id;
					res_status_q <= STAT_NONE;
					res_core_q   <= '0;
					res_jid_q    <= '0;
				end
			end
			S_NEW: begin
				slot_q <= free_idx;
				if (!free_v) begin
					res_status_q <= STAT_FULL;
				end else if (idle_v) begin
					hold_idx_q[idle_core] <= free_idx;
					res_status_q          <= STAT_PLACED;
					res_core_q            <= 3'(idle_core);
					res_jid_q             <= id_q;
				end
			end
			S_SCAN: begin
				if (scan_q != '0 && cand) begin
					best_core_q <= CW'(scan_q - 1'b1);
					best_rec_q  <= rd_q;
					best_eff_q  <= eff;
				end
			end
			S_VIC: begin
				hold_idx_q[best_core_q] <= slot_q;
				res_status_q            <= STAT_PLACED;
				res_core_q              <= 3'(best_core_q);
				res_jid_q               <= id_q;
			end
			S_EV_HELD: begin
				held_rec_q <= rd_q;
				t_turn_q   <= turn;
				t_wait_q   <= wt;
				t_resp_q   <= rsp;
			end
			S_EV_POP: begin
				head_q <= q_head;
				if (q_empty && op_q == OP_QUANTUM && held_v_q) begin
					res_status_q <= STAT_PLACED;
					res_core_q   <= core_q;
					res_jid_q    <= held_rec_q.job;
				end
			end
			S_EV_HEAD: begin
				hold_idx_q[cidx] <= head_q;
				res_status_q     <= STAT_PLACED;
				res_core_q       <= core_q;
				res_jid_q        <= rd_q.job;
			end
			S_DONE: begin
				if (out_free) begin
					status_q           <= res_status_q;
					core_index_q       <= res_core_q;
					run_job_id_q       <= res_jid_q;
					done_count_q       <= sum_done_q;
					wait_total_q       <= sum_wait_q;
					turnaround_total_q <= sum_turn_q;
					response_total_q   <= sum_resp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign core_index       = core_index_q;
	assign run_job_id       = run_job_id_q;
	assign done_count       = done_count_q;
	assign wait_total       = wait_total_q;
	assign turnaround_total = turnaround_total_q;
	assign response_total   = response_total_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.pop |-> !q_empty)
		else $error("queue pop while empty");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_ctl.push && q_ctl.pop))
		else $error("queue push and pop in one cycle");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken without going busy");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("record write outside event work");

endmodule

[rtl/core/mjs_qcell.sv]
// ----------------------------------------------------------------------------
// mjs_qcell
// One slot of the sorted wait queue: holds an entry, shifts left on pop and
// right on insert, and compares the incoming key against its own.
// ----------------------------------------------------------------------------
module mjs_qcell import mjs_pkg::*; #(
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    scheme,
	input  qctl_t         ctl,
	input  logic          s_here,
	input  logic          s_prev,
	input  logic [IW-1:0] new_idx,
	input  qkey_t         new_key,
	input  logic          left_v,
	input  logic [IW-1:0] left_idx,
	input  qkey_t         left_key,
	input  logic          right_v,
	input  logic [IW-1:0] right_idx,
	input  qkey_t         right_key,
	output logic          v,
	output logic [IW-1:0] idx,
	output qkey_t         key,
	output logic          b
);

	logic          v_q;
	logic [IW-1:0] idx_q;
	qkey_t         key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.pop) begin
			v_q <= right_v;
		end else if (ctl.push && s_here) begin
			v_q <= s_prev ? left_v : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			idx_q <= right_idx;
			key_q <= right_key;
		end else if (ctl.push && s_here) begin
			idx_q <= s_prev ? left_idx : new_idx;
			key_q <= s_prev ? left_key : new_key;
		end
	end

	assign v   = v_q;
	assign idx = idx_q;
	assign key = key_q;
	// empty slots always lie behind the insert point
	assign b   = !v_q || goes_before(scheme, new_key, key_q);

endmodule

[rtl/core/mjs_queue.sv]
// ----------------------------------------------------------------------------
// mjs_queue
// Sorted wait queue built as a chain of cells; head is cell zero.
// ----------------------------------------------------------------------------
module mjs_queue import mjs_pkg::*; #(
	parameter int DEPTH = MAX_JOBS_DEF,
	parameter int IW    = $clog2(MAX_JOBS_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    scheme,
	input  qctl_t         ctl,
	input  logic [IW-1:0] push_idx,
	input  qkey_t         push_key,
	output logic [IW-1:0] head_idx,
	output logic          empty,
	output logic          full
);

	logic          v   [DEPTH];
	logic [IW-1:0] idx [DEPTH];
	qkey_t         key [DEPTH];
	logic          b   [DEPTH];
	logic          s   [DEPTH];
	logic          sp  [DEPTH];
	logic          l_v [DEPTH];
	logic [IW-1:0] l_idx [DEPTH];
	qkey_t         l_key [DEPTH];
	logic          r_v [DEPTH];
	logic [IW-1:0] r_idx [DEPTH];
	qkey_t         r_key [DEPTH];

	// s marks the slots at or behind the insert point
	always_comb begin
		for (int j = DEPTH - 1; j >= 0; j--) begin
			if (j == DEPTH - 1) s[j] = b[j];
			else s[j] = b[j] && s[j+1];
		end
		for (int j = 0; j < DEPTH; j++) begin
			if (j > 0) begin
				sp[j]    = s[j-1];
				l_v[j]   = v[j-1];
				l_idx[j] = idx[j-1];
				l_key[j] = key[j-1];
			end else begin
				sp[j]    = 1'b0;
				l_v[j]   = 1'b0;
				l_idx[j] = '0;
				l_key[j] = '0;
			end
			if (j < DEPTH - 1) begin
				r_v[j]   = v[j+1];
				r_idx[j] = idx[j+1];
				r_key[j] = key[j+1];
			end else begin
				r_v[j]   = 1'b0;
				r_idx[j] = '0;
				r_key[j] = '0;
			end
		end
	end

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		mjs_qcell #(.IW(IW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.scheme    (scheme),
			.ctl       (ctl),
			.s_here    (s[j]),
			.s_prev    (sp[j]),
			.new_idx   (push_idx),
			.new_key   (push_key),
			.left_v    (l_v[j]),
			.left_idx  (l_idx[j]),
			.left_key  (l_key[j]),
			.right_v   (r_v[j]),
			.right_idx (r_idx[j]),
			.right_key (r_key[j]),
			.v         (v[j]),
			.idx       (idx[j]),
			.key       (key[j]),
			.b         (b[j])
		);
	end

	assign head_idx = idx[0];
	assign empty    = !v[0];
	assign full     = v[DEPTH-1];

endmodule

[tb/tb_multicore_job_scheduler_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multicore_job_scheduler_top
// Self-checking bench for the job scheduler: drives new-job, finish and
// quantum events under every scheme and many core counts, predicts each result
// beat in a scoreboard model and compares all fields, with random idling.
// ----------------------------------------------------------------------------
import mjs_pkg::*;

typedef struct {
	logic [1:0]  op;
	logic [15:0] job;
	logic [31:0] tnow;
	logic [15:0] len;
	logic [7:0]  prio;
	logic [2:0]  core;
} sched_event_t;

typedef struct {
	logic [1:0]  status;
	logic [2:0]  core;
	logic [15:0] job;
	logic [31:0] done;
	logic [47:0] wait_sum;
	logic [47:0] turn_sum;
	logic [47:0] resp_sum;
} sched_result_t;

class sched_scoreboard;
	logic [2:0]  scheme;
	logic [3:0]  cores;
	logic [15:0] jnum[64];
	logic [31:0] arr[64];
	logic [7:0]  urg[64];
	logic [15:0] left[64];
	logic [15:0] len[64];
	logic [32:0] first[64];
	logic [31:0] last[64];
	logic [32:0] prev[64];
	bit          used[64];
	int          holds[8];
	int          ready_q[$];
	logic [31:0] done_n;
	logic [47:0] wait_sum, turn_sum, resp_sum;
	sched_result_t pending[$];
	int          errors;

	function new();
		scheme = SCH_FCFS;
		cores = 4'd1;
		foreach (used[i]) used[i] = 0;
		foreach (holds[i]) holds[i] = 0;
		done_n = 0;
		wait_sum = 0;
		turn_sum = 0;
		resp_sum = 0;
		errors = 0;
	endfunction

	function void write_reg(logic idx, logic [3:0] val);
		if (idx == CFG_SCHEME) scheme = val[2:0];
		else cores = val;
	endfunction

	function bit ahead(int a, int b);
		if (scheme == SCH_SJF || scheme == SCH_PSJF) begin
			if (left[a] != left[b]) return left[a] < left[b];
			return arr[a] < arr[b];
		end
		if (scheme == SCH_PRI || scheme == SCH_PPRI) begin
			if (urg[a] != urg[b]) return urg[a] < urg[b];
			return arr[a] < arr[b];
		end
		return 0;
	endfunction

	function void push_ready(int r);
		int pos;
		if (ready_q.size() >= 64) return;
		pos = ready_q.size();
		while (pos > 0 && ahead(r, ready_q[pos - 1])) pos--;
		ready_q.insert(pos, r);
	endfunction

	function logic [31:0] prev32(int r);
		return prev[r][32] ? prev[r][31:0] : 32'hFFFF_FFFF;
	endfunction

	// take back the start stamps of a job displaced in the tick it started
	function void unseat(int r, logic [31:0] t);
		if (first[r][32] && first[r][31:0] == t) begin
			first[r] = 0;
			last[r] = prev32(r);
		end else if (last[r] == t) begin
			last[r] = prev32(r);
		end
	endfunction

	function logic [47:0] sat_add(logic [47:0] s, longint term);
		if (term <= 0) return s;
		if (term >= longint'(MAX48 - s)) return MAX48;
		return s + term[47:0];
	endfunction

	function void retire(int r, logic [31:0] t);
		longint turn, resp;
		turn = longint'(t) - longint'(arr[r]);
		resp = 0;
		if (done_n != 32'hFFFF_FFFF) done_n++;
		wait_sum = sat_add(wait_sum, turn - longint'(len[r]));
		turn_sum = sat_add(turn_sum, turn);
		if (first[r][32]) resp = longint'(first[r][31:0]) - longint'(arr[r]);
		resp_sum = sat_add(resp_sum, resp);
	endfunction

	function void note_event(sched_event_t ev);
		sched_result_t res;
		int n, slot, best, o, bo, held, nx;
		longint best_eff, eff, sd;
		logic [31:0] d;
		res = '{status: STAT_NONE, core: 0, job: 0, done: 0, wait_sum: 0,
			turn_sum: 0, resp_sum: 0};
		n = cores > 8 ? 8 : cores;
		if (ev.op == OP_NEW) begin
			slot = -1;
			for (int r = 0; r < 64; r++)
				if (!used[r]) begin
					slot = r;
					break;
				end
			if (slot < 0) begin
				res.status = STAT_FULL;
			end else begin
				best = -1;
				best_eff = 0;
				used[slot] = 1;
				jnum[slot] = ev.job;
				arr[slot] = ev.tnow;
				urg[slot] = ev.prio;
				left[slot] = ev.len;
				len[slot] = ev.len;
				first[slot] = 0;
				last[slot] = 0;
				prev[slot] = 0;
				for (int c = 0; c < n; c++)
					if (holds[c] == 0) begin
						best = c;
						break;
					end
				if (best >= 0) begin
					first[slot] = {1'b1, ev.tnow};
					if (scheme == SCH_PSJF || scheme == SCH_PPRI) last[slot] = ev.tnow;
				end else if (scheme == SCH_PPRI) begin
					for (int c = 0; c < n; c++) begin
						o = (holds[c] - 1) % 64;
						if (urg[o] > ev.prio) begin
							bo = best < 0 ? 0 : (holds[best] - 1) % 64;
							if (best < 0 || urg[o] > urg[bo] ||
									(urg[o] == urg[bo] && arr[bo] < arr[o]))
								best = c;
						end
					end
				end else if (scheme == SCH_PSJF) begin
					for (int c = 0; c < n; c++) begin
						o = (holds[c] - 1) % 64;
						d = ev.tnow - last[o];
						sd = longint'(int'(d));
						eff = longint'(left[o]) - sd;
						if (eff > longint'(ev.len) && (best < 0 || eff > best_eff)) begin
							best = c;
							best_eff = eff;
						end
					end
				end
				if (best >= 0 && holds[best] != 0) begin
					o = (holds[best] - 1) % 64;
					first[slot] = {1'b1, ev.tnow};
					last[slot] = ev.tnow;
					if (scheme == SCH_PSJF) left[o] = best_eff > 65535 ? 16'hFFFF : best_eff[15:0];
					unseat(o, ev.tnow);
					push_ready(o);
				end
				if (best >= 0) begin
					holds[best] = slot + 1;
					res.status = STAT_PLACED;
					res.core = best[2:0];
					res.job = ev.job;
				end else begin
					push_ready(slot);
				end
			end
		end else if (ev.op == OP_FINISH || ev.op == OP_QUANTUM) begin
			held = holds[ev.core];
			if (ev.op == OP_FINISH && held != 0) begin
				retire(held - 1, ev.tnow);
				used[held - 1] = 0;
				holds[ev.core] = 0;
			end
			nx = ready_q.size() ? ready_q.pop_front() : -1;
			if (nx >= 0) begin
				if (!first[nx][32]) begin
					if (ev.op == OP_FINISH) prev[nx] = 0;
					first[nx] = {1'b1, ev.tnow};
				end else if (ev.op == OP_FINISH) begin
					prev[nx] = {1'b1, last[nx]};
				end
				last[nx] = ev.tnow;
				holds[ev.core] = nx + 1;
				if (ev.op == OP_QUANTUM && held != 0) push_ready(held - 1);
				res.status = STAT_PLACED;
				res.core = ev.core;
				res.job = jnum[nx];
			end else if (ev.op == OP_QUANTUM && held != 0) begin
				res.status = STAT_PLACED;
				res.core = ev.core;
				res.job = jnum[held - 1];
			end
		end
		res.done = done_n;
		res.wait_sum = wait_sum;
		res.turn_sum = turn_sum;
		res.resp_sum = resp_sum;
		pending.push_back(res);
	endfunction

	function void check_result(sched_result_t got);
		sched_result_t want;
		string nm[7];
		logic [63:0] e[7], a[7];
		if (pending.size() == 0) begin
			$error("result beat with nothing expected");
			errors++;
			return;
		end
		want = pending.pop_front();
		nm = '{"status", "core_index", "run_job_id", "done_count", "wait_total",
			"turnaround_total", "response_total"};
		e = '{want.status, want.core, want.job, want.done, want.wait_sum,
			want.turn_sum, want.resp_sum};
		a = '{got.status, got.core, got.job, got.done, got.wait_sum,
			got.turn_sum, got.resp_sum};
		for (int i = 0; i < 7; i++)
			if (e[i] !== a[i]) begin
				$error("%s: expected %0h, got %0h", nm[i], e[i], a[i]);
				errors++;
			end
	endfunction
endclass

module tb_multicore_job_scheduler_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  opcode = OP_NEW;
	logic [15:0] job_id = 0;
	logic [31:0] now = 0;
	logic [15:0] run_length = 1;
	logic [7:0]  prio_level = 0;
	logic [2:0]  core_id = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [2:0]  core_index;
	logic [15:0] run_job_id;
	logic [31:0] done_count;
	logic [47:0] wait_total, turnaround_total, response_total;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [3:0]  cfg_data = 0;

	sched_scoreboard sb = new();
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic [31:0] clock_ticks = 0;

	multicore_job_scheduler_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver side: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{status, core_index, run_job_id, done_count, wait_total,
				turnaround_total, response_total});

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_event(sched_event_t ev);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		opcode <= ev.op;
		job_id <= ev.job;
		now <= ev.tnow;
		run_length <= ev.len;
		prio_level <= ev.prio;
		core_id <= ev.core;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_event(ev);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic sched_event_t make_event(logic [1:0] op, logic [15:0] job,
		logic [31:0] t, logic [15:0] l, logic [7:0] p, logic [2:0] c);
		sched_event_t ev;
		ev = '{op: op, job: job, tnow: t, len: l, prio: p, core: c};
		return ev;
	endfunction

	// mostly a well-formed timeline, with some odd times and unused opcodes
	function automatic sched_event_t random_event(int new_pct);
		sched_event_t ev;
		int roll;
		clock_ticks += $urandom_range(0, 25);
		roll = $urandom_range(99);
		ev.op = roll < new_pct ? OP_NEW : roll < new_pct + (97 - new_pct) * 6 / 10 ? OP_FINISH :
			roll < 97 ? OP_QUANTUM : OP_UNUSED;
		ev.job = 16'($urandom_range(16'hFFFF));
		ev.tnow = $urandom_range(99) < 3 ? $urandom() : clock_ticks;
		ev.len = $urandom_range(99) < 10 ? 16'($urandom_range(1, 16'hFFFF)) :
			16'($urandom_range(1, 200));
		ev.prio = $urandom_range(99) < 50 ? 8'($urandom_range(255)) : 8'($urandom_range(3));
		ev.core = 3'($urandom_range(7));
		return ev;
	endfunction

	initial begin
		logic [3:0] core_set[12];
		core_set = '{4'd1, 4'd8, 4'd3, 4'd2, 4'd15, 4'd4, 4'd0, 4'd8, 4'd5, 4'd1, 4'd7, 4'd2};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: preemptive priority on two cores, then preemptive SJF, field extremes, odd cases
		write_reg(CFG_SCHEME, 4'(SCH_PPRI));
		write_reg(CFG_CORES, 4'd2);
		send_event(make_event(OP_NEW, 16'h0000, 32'd0, 16'd1, 8'd255, 3'd0));
		send_event(make_event(OP_NEW, 16'hFFFF, 32'd0, 16'hFFFF, 8'd200, 3'd0));
		send_event(make_event(OP_NEW, 16'h0011, 32'd0, 16'd5, 8'd0, 3'd0));
		send_event(make_event(OP_NEW, 16'h0012, 32'd1, 16'd5, 8'd200, 3'd0));
		send_event(make_event(OP_NEW, 16'h0013, 32'd2, 16'd9, 8'd0, 3'd0));
		send_event(make_event(OP_QUANTUM, 16'd0, 32'd3, 16'd1, 8'd0, 3'd0));
		send_event(make_event(OP_FINISH, 16'd0, 32'd10, 16'd1, 8'd0, 3'd1));
		send_event(make_event(OP_FINISH, 16'd0, 32'd11, 16'd1, 8'd0, 3'd7));
		send_event(make_event(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 3'd7));
		send_event(make_event(OP_FINISH, 16'd0, 32'hFFFF_FFFF, 16'd1, 8'd0, 3'd0));
		drain();
		write_reg(CFG_SCHEME, 4'(SCH_PSJF));
		send_event(make_event(OP_NEW, 16'h0021, 32'd20, 16'd300, 8'd1, 3'd0));
		send_event(make_event(OP_NEW, 16'h0022, 32'd20, 16'd2, 8'd1, 3'd0));
		send_event(make_event(OP_NEW, 16'h0023, 32'd21, 16'd1, 8'd1, 3'd0));
		send_event(make_event(OP_FINISH, 16'd0, 32'd22, 16'd1, 8'd0, 3'd0));
		send_event(make_event(OP_FINISH, 16'd0, 32'd30, 16'd1, 8'd0, 3'd1));
		drain();
		write_reg(CFG_SCHEME, 4'd7);
		write_reg(CFG_CORES, 4'd0);
		send_event(make_event(OP_NEW, 16'h0031, 32'd40, 16'd4, 8'd4, 3'd0));
		send_event(make_event(OP_QUANTUM, 16'd0, 32'd41, 16'd1, 8'd0, 3'd3));
		drain();

		// pressure: receiver holds off while a burst of new jobs fills the store
		write_reg(CFG_SCHEME, 4'(SCH_FCFS));
		write_reg(CFG_CORES, 4'd1);
		hold_reqs <= hold_reqs + 1;
		repeat (80) send_event(random_event(100));
		drain();

		for (int p = 0; p < 12; p++) begin
			write_reg(CFG_SCHEME, 4'(p % 6));
			write_reg(CFG_CORES, core_set[p]);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 79;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 79;
				end
				default: begin
					idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			repeat (108) send_event(random_event(48));
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
rtl/core/mjs_pkg.sv
rtl/core/mjs_qcell.sv
rtl/core/mjs_queue.sv
rtl/core/multicore_job_scheduler_top.sv
tb/tb_multicore_job_scheduler_top.sv
